FILE: rtl/core/slpg_pkg.sv
// Package for the status LED pattern generator.
// Holds the register indexes, mode and pattern codes and reset values.
// No dependencies; every other file of the block imports it.
package slpg_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SLOW_PERIOD   = 2'd0;
  localparam cfg_idx_t CFG_MEDIUM_PERIOD = 2'd1;
  localparam cfg_idx_t CFG_FAST_PERIOD   = 2'd2;
  localparam cfg_idx_t CFG_DOUBLE_STEP   = 2'd3;

  localparam period_t SLOW_PERIOD_RST   = 16'd1000;
  localparam period_t MEDIUM_PERIOD_RST = 16'd500;
  localparam period_t FAST_PERIOD_RST   = 16'd200;
  localparam period_t DOUBLE_STEP_RST   = 16'd100;

  typedef enum logic [1:0] {
    MODE_ON     = 2'd0,
    MODE_SLOW   = 2'd1,
    MODE_MEDIUM = 2'd2,
    MODE_FAST   = 2'd3
  } led1_mode_t;

  typedef logic [2:0] pattern_t;

  localparam pattern_t PAT_OFF    = 3'd0;
  localparam pattern_t PAT_ON     = 3'd1;
  localparam pattern_t PAT_DOUBLE = 3'd5;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_LOW1   = 2'd1,
    PH_HIGH2  = 2'd2,
    PH_FINISH = 2'd3
  } blink_phase_t;

endpackage

FILE: rtl/core/slpg_in_if.sv
// Request channel of the status LED pattern generator: one poll per request.
// Carries valid, ready and the poll fields; uses slpg_pkg for the pattern type.
interface slpg_in_if
  import slpg_pkg::*;
();
  logic     valid;
  logic     ready;
  logic     ota_in_progress;
  logic     ble_provisioning;
  logic     ir_learning;
  logic     wifi_connected;
  logic     mqtt_connected;
  tick_t    now_ticks;
  logic     led2_write;
  pattern_t led2_new_pattern;

  modport source (
    output valid, ota_in_progress, ble_provisioning, ir_learning, wifi_connected,
           mqtt_connected, now_ticks, led2_write, led2_new_pattern,
    input  ready
  );

  modport sink (
    input  valid, ota_in_progress, ble_provisioning, ir_learning, wifi_connected,
           mqtt_connected, now_ticks, led2_write, led2_new_pattern,
    output ready
  );
endinterface

FILE: rtl/core/slpg_out_if.sv
// Result channel of the status LED pattern generator: one result per poll.
// Carries valid, ready, both LED levels and the LED1 mode; uses slpg_pkg.
interface slpg_out_if
  import slpg_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       led1_level;
  logic       led2_level;
  logic [1:0] led1_mode;

  modport source (
    output valid, led1_level, led2_level, led1_mode,
    input  ready
  );

  modport sink (
    input  valid, led1_level, led2_level, led1_mode,
    output ready
  );
endinterface

FILE: rtl/core/status_led_pattern_generator_top.sv
// Top level of the status LED pattern generator.
// Depends on slpg_pkg, slpg_in_if and slpg_out_if.
//
// Usage:
//   Each request on in_ch is one poll: five status flags, the tick count and
//   an optional new LED2 pattern. For every accepted request exactly one
//   result appears on out_ch with both LED levels and the chosen LED1 mode.
//   The result is registered and is valid in the cycle after acceptance.
//   Throughput is one request per cycle while results are taken, set by the
//   single LED state update: a 32-bit subtract and compare per LED.
//   The result register holds a finished result while the receiver stalls;
//   a new request is accepted in the same cycle the held result is taken,
//   and none is accepted while the result register is full and not taken.
//   The cfg_ port writes the four 16-bit period registers; the user must
//   write only while no request is in flight; the block does not enforce it.
//   A synchronous active-low reset turns both LEDs off, clears the timers,
//   selects pattern off for LED2, empties the result register and loads the
//   default periods 1000, 500, 200 and 100 ticks.
module status_led_pattern_generator_top
  import slpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  slpg_in_if.sink     in_ch,
  slpg_out_if.source  out_ch,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  period_t     cfg_wdata
);

  period_t      slow_period_r, medium_period_r, fast_period_r, double_step_r;

  logic         led1_pin_r, led1_pin_nxt;
  logic         led1_toggle_r, led1_toggle_nxt;
  tick_t        led1_last_r, led1_last_nxt;
  logic         led2_pin_r, led2_pin_nxt;
  tick_t        led2_last_r, led2_last_nxt;
  blink_phase_t phase_r, phase_nxt;
  pattern_t     pattern_r, pattern_nxt;

  logic         out_valid_r;
  logic         out_led1_r, out_led2_r;
  led1_mode_t   out_mode_r;

  logic         accept;
  led1_mode_t   mode;
  period_t      period;
  tick_t        led1_diff;
  tick_t        led2_diff;
  logic         step_done;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r   <= SLOW_PERIOD_RST;
      medium_period_r <= MEDIUM_PERIOD_RST;
      fast_period_r   <= FAST_PERIOD_RST;
      double_step_r   <= DOUBLE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOW_PERIOD:   slow_period_r   <= cfg_wdata;
        CFG_MEDIUM_PERIOD: medium_period_r <= cfg_wdata;
        CFG_FAST_PERIOD:   fast_period_r   <= cfg_wdata;
        CFG_DOUBLE_STEP:   double_step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_ch.ota_in_progress) begin
      mode = MODE_FAST;
    end else if (in_ch.ble_provisioning) begin
      mode = MODE_MEDIUM;
    end else if (in_ch.ir_learning) begin
      mode = MODE_FAST;
    end else if (in_ch.wifi_connected) begin
      mode = in_ch.mqtt_connected ? MODE_ON : MODE_MEDIUM;
    end else begin
      mode = MODE_SLOW;
    end
  end

  always_comb begin
    case (mode)
      MODE_SLOW:   period = slow_period_r;
      MODE_MEDIUM: period = medium_period_r;
      default:     period = fast_period_r;
    endcase
  end

  assign led1_diff = in_ch.now_ticks - led1_last_r;
  assign led2_diff = in_ch.now_ticks - led2_last_r;
  assign step_done = led2_diff >= {{(TICK_W-PERIOD_W){1'b0}}, double_step_r};

  always_comb begin
    led1_pin_nxt    = led1_pin_r;
    led1_toggle_nxt = led1_toggle_r;
    led1_last_nxt   = led1_last_r;
    if (mode == MODE_ON) begin
      led1_pin_nxt = 1'b1;
    end else if (led1_diff >= {{(TICK_W-PERIOD_W){1'b0}}, period}) begin
      led1_toggle_nxt = !led1_toggle_r;
      led1_pin_nxt    = !led1_toggle_r;
      led1_last_nxt   = in_ch.now_ticks;
    end
  end

  always_comb begin
    pattern_nxt   = in_ch.led2_write ? in_ch.led2_new_pattern : pattern_r;
    led2_pin_nxt  = led2_pin_r;
    led2_last_nxt = led2_last_r;
    phase_nxt     = phase_r;
    if (pattern_nxt != PAT_DOUBLE) begin
      led2_pin_nxt = (pattern_nxt == PAT_ON);
    end else begin
      case (phase_r)
        PH_START: begin
          led2_pin_nxt  = 1'b1;
          led2_last_nxt = in_ch.now_ticks;
          phase_nxt     = PH_LOW1;
        end
        PH_LOW1: begin
          if (step_done) begin
            led2_pin_nxt  = 1'b0;
            led2_last_nxt = in_ch.now_ticks;
            phase_nxt     = PH_HIGH2;
          end
        end
        PH_HIGH2: begin
          if (step_done) begin
            led2_pin_nxt  = 1'b1;
            led2_last_nxt = in_ch.now_ticks;
            phase_nxt     = PH_FINISH;
          end
        end
        default: begin
          if (step_done) begin
            led2_pin_nxt = 1'b0;
            pattern_nxt  = PAT_OFF;
            phase_nxt    = PH_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led1_pin_r    <= 1'b0;
      led1_toggle_r <= 1'b0;
      led1_last_r   <= '0;
      led2_pin_r    <= 1'b0;
      led2_last_r   <= '0;
      phase_r       <= PH_START;
      pattern_r     <= PAT_OFF;
    end else if (accept) begin
      led1_pin_r    <= led1_pin_nxt;
      led1_toggle_r <= led1_toggle_nxt;
      led1_last_r   <= led1_last_nxt;
      led2_pin_r    <= led2_pin_nxt;
      led2_last_r   <= led2_last_nxt;
      phase_r       <= phase_nxt;
      pattern_r     <= pattern_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_led1_r <= led1_pin_nxt;
      out_led2_r <= led2_pin_nxt;
      out_mode_r <= mode;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.led1_level = out_led1_r;
  assign out_ch.led2_level = out_led2_r;
  assign out_ch.led1_mode  = out_mode_r;

endmodule

FILE: sim/slpg_led_checker.sv
`timescale 1ns / 1ps
// Checker for the status LED pattern generator: predicts the LED levels and mode for
// each accepted poll and compares them with the result channel.
// Depends on slpg_pkg, slpg_in_if and slpg_out_if.
module slpg_led_checker
  import slpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  slpg_in_if       in_ch,
  slpg_out_if      out_ch,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  period_t  cfg_wdata,
  output int       mismatches,
  output int       outstanding
);

  typedef struct packed {
    logic       led1;
    logic       led2;
    led1_mode_t mode;
  } led_result_t;

  period_t      slow_span;
  period_t      medium_span;
  period_t      fast_span;
  period_t      step_span;
  logic         led1_pin;
  logic         led1_blink;
  tick_t        led1_since;
  logic         led2_pin;
  tick_t        led2_since;
  blink_phase_t phase;
  pattern_t     pat_now;

  led_result_t  expected_levels[$];

  task report_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    mismatches++;
  endtask

  function bit time_up(input tick_t now_t, input tick_t since, input period_t span);
    tick_t gap;
    gap = now_t - since;
    return gap >= tick_t'(span);
  endfunction

  function led_result_t poll_leds(input logic ota, input logic ble, input logic ir,
                                  input logic wifi, input logic mqtt, input tick_t now_t,
                                  input logic wr, input pattern_t pat);
    led1_mode_t  mode;
    period_t     span;
    led_result_t res;
    if (wr) begin
      pat_now = pat;
    end
    if (ota) begin
      mode = MODE_FAST;
    end else if (ble) begin
      mode = MODE_MEDIUM;
    end else if (ir) begin
      mode = MODE_FAST;
    end else if (wifi) begin
      if (mqtt) begin
        mode = MODE_ON;
      end else begin
        mode = MODE_MEDIUM;
      end
    end else begin
      mode = MODE_SLOW;
    end

    // Steady on leaves the blink level and its timer untouched.
    if (mode == MODE_ON) begin
      led1_pin = 1'b1;
    end else begin
      case (mode)
        MODE_SLOW: begin
          span = slow_span;
        end
        MODE_MEDIUM: begin
          span = medium_span;
        end
        default: begin
          span = fast_span;
        end
      endcase
      if (time_up(now_t, led1_since, span)) begin
        led1_blink = ~led1_blink;
        led1_pin   = led1_blink;
        led1_since = now_t;
      end
    end

    if (pat_now != PAT_DOUBLE) begin
      led2_pin = (pat_now == PAT_ON);
    end else begin
      case (phase)
        PH_START: begin
          led2_pin   = 1'b1;
          led2_since = now_t;
          phase      = PH_LOW1;
        end
        PH_LOW1: begin
          if (time_up(now_t, led2_since, step_span)) begin
            led2_pin   = 1'b0;
            led2_since = now_t;
            phase      = PH_HIGH2;
          end
        end
        PH_HIGH2: begin
          if (time_up(now_t, led2_since, step_span)) begin
            led2_pin   = 1'b1;
            led2_since = now_t;
            phase      = PH_FINISH;
          end
        end
        default: begin
          if (time_up(now_t, led2_since, step_span)) begin
            led2_pin = 1'b0;
            pat_now  = PAT_OFF;
            phase    = PH_START;
          end
        end
      endcase
    end

    res.led1 = led1_pin;
    res.led2 = led2_pin;
    res.mode = mode;
    return res;
  endfunction

  always @(posedge clk) begin
    led_result_t want;
    if (!rst_n) begin
      mismatches  = 0;
      slow_span   = SLOW_PERIOD_RST;
      medium_span = MEDIUM_PERIOD_RST;
      fast_span   = FAST_PERIOD_RST;
      step_span   = DOUBLE_STEP_RST;
      led1_pin    = 1'b0;
      led1_blink  = 1'b0;
      led1_since  = '0;
      led2_pin    = 1'b0;
      led2_since  = '0;
      phase       = PH_START;
      pat_now     = PAT_OFF;
      expected_levels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOW_PERIOD: begin
            slow_span = cfg_wdata;
          end
          CFG_MEDIUM_PERIOD: begin
            medium_span = cfg_wdata;
          end
          CFG_FAST_PERIOD: begin
            fast_span = cfg_wdata;
          end
          default: begin
            step_span = cfg_wdata;
          end
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          want = expected_levels.pop_front();
          if (out_ch.led1_level !== want.led1) begin
            report_mismatch("led1_level", want.led1, out_ch.led1_level);
          end
          if (out_ch.led2_level !== want.led2) begin
            report_mismatch("led2_level", want.led2, out_ch.led2_level);
          end
          if (out_ch.led1_mode !== want.mode) begin
            report_mismatch("led1_mode", want.mode, out_ch.led1_mode);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        expected_levels.push_back(poll_leds(in_ch.ota_in_progress, in_ch.ble_provisioning,
                                            in_ch.ir_learning, in_ch.wifi_connected,
                                            in_ch.mqtt_connected, in_ch.now_ticks,
                                            in_ch.led2_write, in_ch.led2_new_pattern));
      end
    end
    outstanding = expected_levels.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the status LED pattern generator: drives polls, period writes
// and receiver stalls, and gives the verdict. Depends on slpg_pkg, both channel
// interfaces, the block's top level and slpg_led_checker.
module tb
  import slpg_pkg::*;
();

  localparam logic [4:0] F_NONE = 5'b00000;
  localparam logic [4:0] F_OTA  = 5'b10000;
  localparam logic [4:0] F_BLE  = 5'b01000;
  localparam logic [4:0] F_IR   = 5'b00100;
  localparam logic [4:0] F_WIFI = 5'b00010;
  localparam logic [4:0] F_MQTT = 5'b00001;

  localparam pattern_t PAT_SLOW   = 3'd2;
  localparam pattern_t PAT_MEDIUM = 3'd3;
  localparam pattern_t PAT_FAST   = 3'd4;

  localparam int SEGMENTS     = 6;
  localparam int SEGMENT_POLLS = 280;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  period_t  cfg_wdata;
  int       mismatches;
  int       outstanding;
  int       snd_idle;
  int       rcv_idle;

  slpg_in_if  in_ch ();
  slpg_out_if out_ch ();

  status_led_pattern_generator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slpg_led_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  task send_poll(input logic [4:0] flags, input tick_t t, input logic wr,
                 input pattern_t pat);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.ota_in_progress  <= flags[4];
    in_ch.ble_provisioning <= flags[3];
    in_ch.ir_learning      <= flags[2];
    in_ch.wifi_connected   <= flags[1];
    in_ch.mqtt_connected   <= flags[0];
    in_ch.now_ticks        <= t;
    in_ch.led2_write       <= wr;
    in_ch.led2_new_pattern <= pat;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  task wait_idle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  task write_periods(input period_t slow_p, input period_t medium_p, input period_t fast_p,
                     input period_t step_p);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOW_PERIOD;
    cfg_wdata <= slow_p;
    @(negedge clk);
    cfg_index <= CFG_MEDIUM_PERIOD;
    cfg_wdata <= medium_p;
    @(negedge clk);
    cfg_index <= CFG_FAST_PERIOD;
    cfg_wdata <= fast_p;
    @(negedge clk);
    cfg_index <= CFG_DOUBLE_STEP;
    cfg_wdata <= step_p;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    tick_t      ticks;
    logic [4:0] flags;
    period_t    p0;
    period_t    p1;
    period_t    p2;
    period_t    p3;
    int         step_hi;
    int         roll;
    logic       wr;
    pattern_t   pat;

    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_SLOW_PERIOD;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.ota_in_progress  = 1'b0;
    in_ch.ble_provisioning = 1'b0;
    in_ch.ir_learning      = 1'b0;
    in_ch.wifi_connected   = 1'b0;
    in_ch.mqtt_connected   = 1'b0;
    in_ch.now_ticks        = '0;
    in_ch.led2_write       = 1'b0;
    in_ch.led2_new_pattern = PAT_OFF;
    snd_idle               = 9;
    rcv_idle               = 68;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polls under the reset periods.
    send_poll(F_NONE, 32'd0, 1'b1, PAT_ON);
    send_poll(F_OTA, 32'd200, 1'b1, PAT_OFF);
    send_poll(F_BLE, 32'd700, 1'b1, PAT_SLOW);
    send_poll(F_IR, 32'd900, 1'b1, PAT_MEDIUM);
    send_poll(F_WIFI | F_MQTT, 32'd900, 1'b1, PAT_FAST);
    send_poll(F_WIFI, 32'd1400, 1'b1, PAT_DOUBLE);
    send_poll(F_NONE, 32'd1450, 1'b0, PAT_OFF);
    send_poll(F_NONE, 32'd1500, 1'b0, PAT_OFF);
    // An interrupted double blink resumes at its stored phase.
    send_poll(F_WIFI | F_MQTT, 32'd1550, 1'b1, PAT_OFF);
    send_poll(F_WIFI | F_MQTT, 32'd1700, 1'b1, PAT_DOUBLE);
    // Rewriting double blink while it runs does not restart it.
    send_poll(F_WIFI | F_MQTT, 32'd1710, 1'b1, PAT_DOUBLE);
    send_poll(F_WIFI, 32'd1810, 1'b0, PAT_OFF);
    send_poll(F_NONE, 32'd1900, 1'b0, PAT_OFF);
    send_poll(5'b11111, 32'hFFFF_FFFF, 1'b1, PAT_DOUBLE);
    send_poll(F_OTA, 32'h0000_0010, 1'b0, PAT_OFF);
    send_poll(F_MQTT, 32'h8000_0000, 1'b0, PAT_OFF);
    send_poll(F_BLE | F_IR, 32'h8000_0100, 1'b0, PAT_OFF);
    send_poll(F_IR | F_WIFI | F_MQTT, 32'h8000_0200, 1'b1, PAT_ON);
    send_poll(F_NONE, 32'h8000_0200, 1'b1, PAT_DOUBLE);
    send_poll(F_NONE, 32'h0000_0000, 1'b0, PAT_OFF);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: begin
          p0 = SLOW_PERIOD_RST;
          p1 = MEDIUM_PERIOD_RST;
          p2 = FAST_PERIOD_RST;
          p3 = DOUBLE_STEP_RST;
        end
        1: begin
          p0 = 16'd1;
          p1 = 16'd1;
          p2 = 16'd1;
          p3 = 16'd1;
        end
        2: begin
          p0 = 16'hFFFF;
          p1 = 16'hFFFF;
          p2 = 16'hFFFF;
          p3 = 16'hFFFF;
        end
        3: begin
          p0 = period_t'($urandom_range(1, 2000));
          p1 = period_t'($urandom_range(1, 2000));
          p2 = period_t'($urandom_range(1, 2000));
          p3 = period_t'($urandom_range(1, 2000));
        end
        4: begin
          p0 = 16'hFFFF;
          p1 = 16'd1;
          p2 = period_t'($urandom_range(1, 5000));
          p3 = period_t'($urandom_range(1, 500));
        end
        default: begin
          p0 = period_t'($urandom_range(1, 65535));
          p1 = period_t'($urandom_range(1, 65535));
          p2 = period_t'($urandom_range(1, 65535));
          p3 = period_t'($urandom_range(1, 65535));
        end
      endcase
      write_periods(p0, p1, p2, p3);

      case (seg / 2)
        0: begin
          snd_idle = 9;
          rcv_idle = 68;
        end
        1: begin
          snd_idle = 68;
          rcv_idle = 9;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase

      step_hi = p0;
      if (p1 > step_hi) step_hi = p1;
      if (p2 > step_hi) step_hi = p2;
      if (p3 > step_hi) step_hi = p3;
      step_hi = step_hi / 3 + 1;

      if (seg % 2 == 1) begin
        ticks = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      end else begin
        ticks = $urandom;
      end
      flags = 5'($urandom_range(0, 31));

      for (int n = 0; n < SEGMENT_POLLS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          ticks = $urandom;
        end else if (roll < 6) begin
          ticks = ticks;
        end else if (roll < 9) begin
          ticks = ticks - tick_t'($urandom_range(1, 50));
        end else begin
          ticks = ticks + tick_t'($urandom_range(0, step_hi));
        end
        if ($urandom_range(0, 9) == 0) begin
          flags = 5'($urandom_range(0, 31));
        end
        wr = ($urandom_range(0, 99) < 8);
        if ($urandom_range(0, 9) < 4) begin
          pat = PAT_DOUBLE;
        end else begin
          pat = pattern_t'($urandom_range(0, 5));
        end
        send_poll(flags, ticks, wr, pat);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/slpg_pkg.sv
rtl/core/slpg_in_if.sv
rtl/core/slpg_out_if.sv
rtl/core/status_led_pattern_generator_top.sv
sim/slpg_led_checker.sv
sim/tb.sv
